@@ rtl/snb_pkg.sv @@
// Shared types and constants for the softened n-body force block.
`timescale 1ns / 1ps

package snb_pkg;

    // Body capacity and derived widths
    localparam int MAX_BODIES = 32;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    // Arithmetic engine job
    typedef enum logic {
        OP_PAIR  = 1'b0,
        OP_ACCEL = 1'b1
    } t_eng_op;

    typedef struct packed {
        logic    go;
        t_eng_op op;
    } t_eng_req;

    typedef struct packed {
        logic done;
        logic clip;
    } t_eng_rsp;

    // One body as it travels along the ring of cells
    typedef struct packed {
        logic                  valid;
        logic [IDX_W-1:0]      idx;
        logic [2:0][31:0]      pos;
        logic [31:0]           mass;
        logic [1:0]            bin;
        logic [2:0][63:0]      acc;
    } t_body;

endpackage

@@ rtl/snb_cell.sv @@
// One ring cell: holds a single body and passes it to its neighbor on a shift.
`timescale 1ns / 1ps

module snb_cell import snb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_clear,
    input  t_body i_d,
    output t_body o_q
);

    logic  r_valid;
    t_body r_body;

    // occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_d.valid;
        end
    end

    // body payload
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_body <= i_d;
        end
    end

    always_comb begin
        o_q       = r_body;
        o_q.valid = r_valid;
    end

endmodule

@@ rtl/snb_div.sv @@
// Restoring divider, one quotient bit per cycle: 128-bit dividend, 101-bit divisor.
`timescale 1ns / 1ps

module snb_div import snb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [127:0] i_num,
    input  logic [100:0] i_den,
    output logic         o_done,
    output logic [63:0]  o_q,
    output logic         o_ovf
);

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [100:0] r_den;
    logic [100:0] r_rem;
    logic [63:0]  r_q;
    logic         r_ovf;

    logic [101:0] n_rem2;
    logic         n_ge;
    logic [100:0] n_rem;

    // one shift-compare-subtract step
    always_comb begin
        n_rem2 = {r_rem, r_num[127]};
        n_ge   = (n_rem2 >= {1'b0, r_den});
        n_rem  = n_ge ? 101'(n_rem2 - {1'b0, r_den}) : n_rem2[100:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd127;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                r_num <= {r_num[126:0], 1'b0};
                r_rem <= n_rem;
                r_q   <= {r_q[62:0], n_ge};
                // a bit leaving the top means the quotient needs more than 64 bits
                r_ovf <= r_ovf | r_q[63];
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_ovf  = r_ovf;

endmodule

@@ rtl/snb_engine.sv @@
// Bit-serial arithmetic engine: pair force terms and force-to-acceleration division.
`timescale 1ns / 1ps

module snb_engine import snb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_eng_req         i_req,
    input  logic [2:0][31:0] i_pos_a,
    input  logic [2:0][31:0] i_pos_b,
    input  logic [31:0]      i_mass_a,
    input  logic [31:0]      i_mass_b,
    input  logic [31:0]      i_grav,
    input  logic [31:0]      i_soft,
    input  logic [2:0][63:0] i_force,
    output t_eng_rsp         o_rsp,
    output logic [2:0][63:0] o_res
);

    typedef enum logic [11:0] {
        E_IDLE = 12'b0000_0000_0001,
        E_SQ   = 12'b0000_0000_0010,
        E_EPS  = 12'b0000_0000_0100,
        E_SQRT = 12'b0000_0000_1000,
        E_DN   = 12'b0000_0001_0000,
        E_GM1  = 12'b0000_0010_0000,
        E_GM2  = 12'b0000_0100_0000,
        E_NUM  = 12'b0000_1000_0000,
        E_DIV  = 12'b0001_0000_0000,
        E_AGO  = 12'b0010_0000_0000,
        E_ADIV = 12'b0100_0000_0000,
        E_DONE = 12'b1000_0000_0000
    } t_eng_state;

    t_eng_state       r_state;
    logic [1:0]       r_c;
    logic [5:0]       r_cnt;
    logic [127:0]     r_ma;
    logic [32:0]      r_mb;
    logic [127:0]     r_acc;
    logic [2:0][31:0] r_dabs;
    logic [2:0]       r_dneg;
    logic [65:0]      r_q;
    logic [66:0]      r_s;
    logic [67:0]      r_rad;
    logic [35:0]      r_rem;
    logic [33:0]      r_root;
    logic [99:0]      r_dn;
    logic [95:0]      r_gmm;
    logic [2:0][63:0] r_res;
    logic             r_clip;

    logic signed [32:0] w_d [3];
    logic [2:0][31:0]   w_dabs;
    logic [2:0]         w_dneg;
    logic [127:0]       n_acc;
    logic [37:0]        n_rem2;
    logic [37:0]        w_trial;
    logic               w_ge;
    logic [35:0]        n_rem;
    logic [33:0]        n_root;
    logic               w_div_go;
    logic [127:0]       w_div_num;
    logic [100:0]       w_div_den;
    logic               w_div_done;
    logic [63:0]        w_div_q;
    logic               w_div_ovf;
    logic [63:0]        w_fabs;
    logic               w_fneg;
    logic [63:0]        w_mag;
    logic [63:0]        w_term;
    logic               w_aclip;
    logic [47:0]        w_aq;

    // position differences and their magnitudes
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_d[c]    = $signed({i_pos_a[c][31], i_pos_a[c]})
                      - $signed({i_pos_b[c][31], i_pos_b[c]});
            w_dneg[c] = w_d[c][32];
            w_dabs[c] = w_d[c][32] ? 32'(-w_d[c]) : w_d[c][31:0];
        end
    end

    // shift-add multiplier step
    assign n_acc = r_acc + (r_mb[0] ? r_ma : '0);

    // digit-by-digit square root step
    always_comb begin
        n_rem2  = {r_rem, r_rad[67:66]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = (n_rem2 >= w_trial);
        n_rem   = w_ge ? 36'(n_rem2 - w_trial) : n_rem2[35:0];
        n_root  = {r_root[32:0], w_ge};
    end

    // force magnitude for the acceleration job
    always_comb begin
        w_fneg = i_force[r_c][63];
        w_fabs = w_fneg ? (~i_force[r_c] + 64'd1) : i_force[r_c];
    end

    // divider feed
    always_comb begin
        w_div_go  = ((r_state == E_NUM) && (r_cnt == '0)) || (r_state == E_AGO);
        w_div_num = (r_state == E_AGO) ? {48'd0, w_fabs, 16'd0} : n_acc;
        w_div_den = (r_state == E_AGO) ? 101'(i_mass_a) : {1'b0, r_dn};
    end

    snb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_div_go),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_q     (w_div_q),
        .o_ovf   (w_div_ovf)
    );

    // pair term: saturated magnitude with the sign of d
    always_comb begin
        w_mag  = (w_div_ovf || w_div_q[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : w_div_q;
        w_term = r_dneg[r_c] ? (~w_mag + 64'd1) : w_mag;
    end

    // acceleration clip to 48-bit signed
    always_comb begin
        if (w_fneg) begin
            w_aclip = w_div_ovf || (w_div_q[63:48] != '0)
                   || (w_div_q[47] && (w_div_q[46:0] != '0));
            w_aq    = w_aclip ? 48'h8000_0000_0000 : (~w_div_q[47:0] + 48'd1);
        end else begin
            w_aclip = w_div_ovf || (w_div_q[63:47] != '0);
            w_aq    = w_aclip ? 48'h7FFF_FFFF_FFFF : w_div_q[47:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.go) begin
                        r_c    <= 2'd0;
                        r_res  <= '0;
                        r_clip <= 1'b0;
                        if (i_req.op == OP_PAIR) begin
                            r_dabs  <= w_dabs;
                            r_dneg  <= w_dneg;
                            r_acc   <= '0;
                            r_ma    <= 128'(w_dabs[0]);
                            r_mb    <= 33'(w_dabs[0]);
                            r_cnt   <= 6'd31;
                            r_state <= E_SQ;
                        end else begin
                            r_state <= E_AGO;
                        end
                    end
                end
                E_SQ, E_EPS, E_DN, E_GM1, E_GM2, E_NUM: begin
                    r_acc <= n_acc;
                    r_ma  <= {r_ma[126:0], 1'b0};
                    r_mb  <= {1'b0, r_mb[32:1]};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        priority case (r_state)
                            E_SQ: begin
                                if (r_c == 2'd2) begin
                                    // coincident bodies contribute nothing
                                    if (n_acc == '0) begin
                                        r_state <= E_DONE;
                                    end else begin
                                        r_q     <= n_acc[65:0];
                                        r_ma    <= 128'(i_soft);
                                        r_mb    <= 33'(i_soft);
                                        r_cnt   <= 6'd31;
                                        r_state <= E_EPS;
                                    end
                                end else begin
                                    r_c   <= r_c + 2'd1;
                                    r_ma  <= 128'(r_dabs[r_c + 2'd1]);
                                    r_mb  <= 33'(r_dabs[r_c + 2'd1]);
                                    r_cnt <= 6'd31;
                                end
                            end
                            E_EPS: begin
                                r_s     <= n_acc[66:0];
                                r_rad   <= {2'b00, r_q};
                                r_rem   <= '0;
                                r_root  <= '0;
                                r_cnt   <= 6'd33;
                                r_state <= E_SQRT;
                            end
                            E_DN: begin
                                r_dn    <= n_acc[99:0];
                                r_acc   <= '0;
                                r_ma    <= 128'(i_grav);
                                r_mb    <= 33'(i_mass_a);
                                r_cnt   <= 6'd31;
                                r_state <= E_GM1;
                            end
                            E_GM1: begin
                                r_acc   <= '0;
                                r_ma    <= 128'(n_acc[63:0]);
                                r_mb    <= 33'(i_mass_b);
                                r_cnt   <= 6'd31;
                                r_state <= E_GM2;
                            end
                            E_GM2: begin
                                r_gmm   <= n_acc[95:0];
                                r_c     <= 2'd0;
                                r_acc   <= '0;
                                r_ma    <= 128'(n_acc[95:0]);
                                r_mb    <= 33'(r_dabs[0]);
                                r_cnt   <= 6'd31;
                                r_state <= E_NUM;
                            end
                            default: begin
                                r_state <= E_DIV;
                            end
                        endcase
                    end
                end
                E_SQRT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_rad  <= {r_rad[65:0], 2'b00};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_acc   <= '0;
                        r_ma    <= 128'(r_s);
                        r_mb    <= n_root[32:0];
                        r_cnt   <= 6'd32;
                        r_state <= E_DN;
                    end
                end
                E_DIV: begin
                    if (w_div_done) begin
                        r_res[r_c] <= w_term;
                        if (r_c == 2'd2) begin
                            r_state <= E_DONE;
                        end else begin
                            r_c     <= r_c + 2'd1;
                            r_acc   <= '0;
                            r_ma    <= 128'(r_gmm);
                            r_mb    <= 33'(r_dabs[r_c + 2'd1]);
                            r_cnt   <= 6'd31;
                            r_state <= E_NUM;
                        end
                    end
                end
                E_AGO: begin
                    r_state <= E_ADIV;
                end
                E_ADIV: begin
                    if (w_div_done) begin
                        r_res[r_c] <= 64'(w_aq);
                        r_clip     <= r_clip | w_aclip;
                        if (r_c == 2'd2) begin
                            r_state <= E_DONE;
                        end else begin
                            r_c     <= r_c + 2'd1;
                            r_state <= E_AGO;
                        end
                    end
                end
                E_DONE: begin
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_state == E_DONE);
    assign o_rsp.clip = r_clip;
    assign o_res      = r_res;

endmodule

@@ rtl/softened_nbody_accel.sv @@
// Top level: body ring, pair scan and result sequencing for softened gravity.
// Load: one body per cycle, input never stalls while loading.
// Compute: each pivot takes a full turn of the ring, and each active pair runs through
//   the bit-serial multiplier, a 34-step square root and three 128-step divisions.
// Results: three 128-step divisions per active body of nonzero mass, none for the others.
// Synchronous active-low reset empties the ring, clears counters, loads register defaults.
`timescale 1ns / 1ps

module softened_nbody_accel import snb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_body_mass,
    input  logic [1:0]         i_step_bin,
    input  logic               i_last_body,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_body_index,
    output logic signed [47:0] o_acc_x,
    output logic signed [47:0] o_acc_y,
    output logic signed [47:0] o_acc_z,
    output logic               o_updated,
    output logic               o_zero_mass,
    output logic               o_saturated,
    output logic               o_overflowed,
    output logic               o_last_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [1:0] CFG_GRAV = 2'd0;
    localparam logic [1:0] CFG_SOFT = 2'd1;
    localparam logic [1:0] CFG_ABIN = 2'd2;

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b0_0000_0001,
        ST_SEEK  = 9'b0_0000_0010,
        ST_PIVOT = 9'b0_0000_0100,
        ST_SCAN  = 9'b0_0000_1000,
        ST_PAIR  = 9'b0_0001_0000,
        ST_WB    = 9'b0_0010_0000,
        ST_EMIT  = 9'b0_0100_0000,
        ST_ACC   = 9'b0_1000_0000,
        ST_OUT   = 9'b1_0000_0000
    } t_state;

    function automatic logic [63:0] f_sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            return sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return sum[63:0];
    endfunction

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_emit;
    logic [IDX_W-1:0] r_step;
    t_body            r_piv;
    logic [31:0]      r_grav;
    logic [31:0]      r_soft;
    logic [1:0]       r_abin;
    logic [4:0]       r_o_idx;
    logic [2:0][47:0] r_o_acc;
    logic             r_o_upd;
    logic             r_o_zm;
    logic             r_o_sat;
    logic             r_o_ovf;
    logic             r_o_last;

    t_body            w_q [MAX_BODIES];
    t_body            w_head;
    t_body            w_tail;
    t_body            w_new;
    logic             w_shift;
    logic             w_clear;
    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_pair_ok;
    logic             w_active;
    logic             w_zm;
    logic             w_head_last;
    logic             w_piv_last;
    t_eng_req         w_req;
    t_eng_rsp         w_rsp;
    logic [2:0][63:0] w_res;
    logic [31:0]      w_eng_mass_a;

    assign w_head     = w_q[0];
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = o_out_valid && !i_out_stall;

    // ring of body cells, head at cell 0, fed at the tail
    genvar k;
    generate
        for (k = 0; k < MAX_BODIES; k++) begin : g_cell
            if (k == MAX_BODIES - 1) begin : g_tail
                snb_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_clear (w_clear),
                    .i_d     (w_tail),
                    .o_q     (w_q[k])
                );
            end else begin : g_mid
                snb_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_clear (w_clear),
                    .i_d     (w_q[k+1]),
                    .o_q     (w_q[k])
                );
            end
        end
    endgenerate

    // incoming body
    always_comb begin
        w_new        = '0;
        w_new.valid  = 1'b1;
        w_new.idx    = r_cnt[IDX_W-1:0];
        w_new.pos[0] = i_pos_x;
        w_new.pos[1] = i_pos_y;
        w_new.pos[2] = i_pos_z;
        w_new.mass   = i_body_mass;
        w_new.bin    = i_step_bin;
    end

    // head and pivot status
    always_comb begin
        w_pair_ok    = (r_piv.bin >= r_abin) && w_head.valid && (w_head.idx > r_piv.idx);
        w_active     = (w_head.bin >= r_abin);
        w_zm         = w_active && (w_head.mass == '0);
        w_head_last  = ((CNT_W'(w_head.idx) + CNT_W'(1)) == r_cnt);
        w_piv_last   = ((CNT_W'(r_piv.idx) + CNT_W'(1)) == r_cnt);
        w_eng_mass_a = ((r_state == ST_EMIT) || (r_state == ST_ACC)) ? w_head.mass
                                                                     : r_piv.mass;
    end

    // ring movement and engine start
    always_comb begin
        w_shift = 1'b0;
        w_clear = 1'b0;
        w_tail  = w_head;
        w_req   = '{go: 1'b0, op: OP_PAIR};
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer && (r_cnt < CNT_W'(MAX_BODIES))) begin
                    w_shift = 1'b1;
                    w_tail  = w_new;
                end
            end
            ST_SEEK: begin
                if (!(w_head.valid && (w_head.idx == '0))) begin
                    w_shift = 1'b1;
                end
            end
            ST_PIVOT: begin
                w_shift = 1'b1;
            end
            ST_SCAN: begin
                if (r_step != '0) begin
                    if (w_pair_ok) begin
                        w_req = '{go: 1'b1, op: OP_PAIR};
                    end else begin
                        w_shift = 1'b1;
                    end
                end
            end
            ST_PAIR: begin
                if (w_rsp.done) begin
                    w_shift = 1'b1;
                    for (int c = 0; c < 3; c++) begin
                        w_tail.acc[c] = f_sat_add(w_head.acc[c], w_res[c]);
                    end
                end
            end
            ST_WB: begin
                // pivot re-enters the ring at the tail with its accumulated force
                w_shift    = 1'b1;
                w_tail.acc = r_piv.acc;
            end
            ST_EMIT: begin
                if (w_active && !w_zm) begin
                    w_req = '{go: 1'b1, op: OP_ACCEL};
                end
            end
            ST_OUT: begin
                if (w_out_xfer) begin
                    if (r_o_last) begin
                        w_clear = 1'b1;
                    end else begin
                        w_shift = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    snb_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_pos_a  (r_piv.pos),
        .i_pos_b  (w_head.pos),
        .i_mass_a (w_eng_mass_a),
        .i_mass_b (w_head.mass),
        .i_grav   (r_grav),
        .i_soft   (r_soft),
        .i_force  (w_head.acc),
        .o_rsp    (w_rsp),
        .o_res    (w_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= 32'd662395188;
            r_soft <= '0;
            r_abin <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRAV: r_grav <= i_cfg_data;
                CFG_SOFT: r_soft <= i_cfg_data;
                CFG_ABIN: r_abin <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (w_in_xfer) begin
                        if (r_cnt < CNT_W'(MAX_BODIES)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_body) begin
                            r_emit  <= 1'b0;
                            r_state <= ST_SEEK;
                        end
                    end
                end
                ST_SEEK: begin
                    if (w_head.valid && (w_head.idx == '0)) begin
                        r_state <= r_emit ? ST_EMIT : ST_PIVOT;
                    end
                end
                ST_PIVOT: begin
                    r_piv   <= w_head;
                    r_step  <= IDX_W'(MAX_BODIES - 1);
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_step == '0) begin
                        r_state <= ST_WB;
                    end else if (w_pair_ok) begin
                        r_state <= ST_PAIR;
                    end else begin
                        r_step <= r_step - IDX_W'(1);
                    end
                end
                ST_PAIR: begin
                    if (w_rsp.done) begin
                        for (int c = 0; c < 3; c++) begin
                            r_piv.acc[c] <= f_sat_add(r_piv.acc[c], ~w_res[c] + 64'd1);
                        end
                        r_step  <= r_step - IDX_W'(1);
                        r_state <= ST_SCAN;
                    end
                end
                ST_WB: begin
                    if (w_piv_last) begin
                        r_emit  <= 1'b1;
                        r_state <= ST_SEEK;
                    end else begin
                        r_state <= ST_PIVOT;
                    end
                end
                ST_EMIT: begin
                    r_o_idx  <= 5'(w_head.idx);
                    r_o_acc  <= '0;
                    r_o_upd  <= w_active;
                    r_o_zm   <= w_zm;
                    r_o_sat  <= 1'b0;
                    r_o_ovf  <= r_ovf;
                    r_o_last <= w_head_last;
                    r_state  <= (w_active && !w_zm) ? ST_ACC : ST_OUT;
                end
                ST_ACC: begin
                    if (w_rsp.done) begin
                        for (int c = 0; c < 3; c++) begin
                            r_o_acc[c] <= w_res[c][47:0];
                        end
                        r_o_sat <= w_rsp.clip;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_xfer) begin
                        if (r_o_last) begin
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // ports
    assign o_in_stall    = (r_state != ST_LOAD);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_cfg_ready   = 1'b1;
    assign o_body_index  = r_o_idx;
    assign o_acc_x       = r_o_acc[0];
    assign o_acc_y       = r_o_acc[1];
    assign o_acc_z       = r_o_acc[2];
    assign o_updated     = r_o_upd;
    assign o_zero_mass   = r_o_zm;
    assign o_saturated   = r_o_sat;
    assign o_overflowed  = r_o_ovf;
    assign o_last_result = r_o_last;

    // checks
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BODIES))
        else $error("body count beyond capacity");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && r_o_last) |=> ((r_cnt == '0) && !r_ovf && (r_state == ST_LOAD)))
        else $error("set not closed after final result");

    a_emit_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_head.valid)
        else $error("result taken from an empty cell");

    a_rsp_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> ((r_state == ST_PAIR) || (r_state == ST_ACC)))
        else $error("engine finished while not awaited");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the softened n-body force block.
`timescale 1ns / 1ps

module testbench;
    import snb_pkg::*;

    typedef enum logic [1:0] {
        REG_GRAV   = 2'd0,
        REG_SOFT   = 2'd1,
        REG_ACTIVE = 2'd2
    } cfg_reg_t;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic [31:0]        mass;
        logic [1:0]         bin;
        logic               last;
    } body_t;

    typedef struct {
        logic [4:0]         idx;
        logic signed [47:0] ax, ay, az;
        logic               upd, zm, sat, ovf, lastr;
    } accel_t;

    localparam logic signed [63:0] F_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] F_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic [79:0]        ACC_TOP = 80'h7FFF_FFFF_FFFF;
    localparam int                 LIMIT   = 20_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0] i_body_mass = '0;
    logic [1:0] i_step_bin = '0;
    logic i_last_body = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_in_stall, o_out_valid, o_cfg_ready;
    logic [4:0] o_body_index;
    logic signed [47:0] o_acc_x, o_acc_y, o_acc_z;
    logic o_updated, o_zero_mass, o_saturated, o_overflowed, o_last_result;

    softened_nbody_accel dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Pending bodies, expected accelerations, mismatch count
    body_t  pending_bodies[$];
    accel_t expected_accels[$];
    int     errors = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     cycles = 0;

    // Shadow of the block: registers, body stores, accumulators
    logic [31:0]        g_shadow = 32'd662395188;
    logic [31:0]        eps_shadow = '0;
    logic [1:0]         abin_shadow = '0;
    logic signed [31:0] body_pos[MAX_BODIES][3];
    logic [31:0]        body_mass[MAX_BODIES];
    logic [1:0]         body_bin[MAX_BODIES];
    logic signed [63:0] force_sum[MAX_BODIES][3];
    int                 loaded = 0;
    logic               dropped = 1'b0;

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63]) return s[64] ? F_MIN : F_MAX;
        return s[63:0];
    endfunction

    // Softened pair force, applied with opposite signs to both bodies
    function automatic void pair_force(int i, int j);
        logic signed [32:0] d[3];
        logic [32:0]        ad[3];
        logic [127:0]       q2, s, dn, gmm, num, qq, t2;
        logic [63:0]        r, tr;
        logic signed [63:0] mag, t;
        q2 = '0;
        for (int c = 0; c < 3; c++) begin
            d[c] = $signed({body_pos[i][c][31], body_pos[i][c]})
                 - $signed({body_pos[j][c][31], body_pos[j][c]});
            ad[c] = d[c] < 0 ? -d[c] : d[c];
            q2 = q2 + 128'(ad[c]) * 128'(ad[c]);
        end
        if (q2 == 0) return;
        s = q2 + 128'(eps_shadow) * 128'(eps_shadow);
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            tr = r | (64'd1 << b);
            t2 = 128'(tr) * 128'(tr);
            if (q2 >= t2) r = tr;
        end
        dn = s * 128'(r);
        gmm = 128'(g_shadow) * 128'(body_mass[i]) * 128'(body_mass[j]);
        for (int c = 0; c < 3; c++) begin
            num = gmm * 128'(ad[c]);
            qq = num / dn;
            mag = (qq > 128'(F_MAX)) ? F_MAX : qq[63:0];
            t = d[c] < 0 ? -mag : mag;
            force_sum[i][c] = sat_sum(force_sum[i][c], -t);
            force_sum[j][c] = sat_sum(force_sum[j][c], t);
        end
    endfunction

    // Force over mass, Q32.16, clipped to 48 bits
    function automatic logic signed [47:0] accel_of(logic signed [63:0] f, logic [31:0] m,
                                                   inout logic clip);
        logic [63:0] mag;
        logic [79:0] q;
        mag = f < 0 ? -f : f;
        q = {mag, 16'd0} / 80'(m);
        if (f >= 0) begin
            if (q > ACC_TOP) begin
                clip = 1'b1;
                return ACC_TOP[47:0];
            end
            return q[47:0];
        end
        if (q > ACC_TOP + 1) begin
            clip = 1'b1;
            q = ACC_TOP + 1;
        end
        return -q[47:0];
    endfunction

    // Store an accepted body; on the last one, predict the whole result set
    function automatic void absorb_body(body_t b);
        accel_t e;
        logic   act;
        if (loaded < MAX_BODIES) begin
            body_pos[loaded][0] = b.px;
            body_pos[loaded][1] = b.py;
            body_pos[loaded][2] = b.pz;
            body_mass[loaded] = b.mass;
            body_bin[loaded] = b.bin;
            loaded++;
        end else begin
            dropped = 1'b1;
        end
        if (!b.last) return;
        for (int i = 0; i < MAX_BODIES; i++)
            for (int c = 0; c < 3; c++) force_sum[i][c] = '0;
        for (int i = 0; i < loaded; i++)
            if (body_bin[i] >= abin_shadow)
                for (int j = i + 1; j < loaded; j++) pair_force(i, j);
        for (int i = 0; i < loaded; i++) begin
            act = body_bin[i] >= abin_shadow;
            e.idx = i[4:0];
            e.ax = '0;
            e.ay = '0;
            e.az = '0;
            e.upd = act;
            e.zm = act && body_mass[i] == 0;
            e.sat = 1'b0;
            if (act && !e.zm) begin
                e.ax = accel_of(force_sum[i][0], body_mass[i], e.sat);
                e.ay = accel_of(force_sum[i][1], body_mass[i], e.sat);
                e.az = accel_of(force_sum[i][2], body_mass[i], e.sat);
            end
            e.ovf = dropped;
            e.lastr = (i + 1 == loaded);
            expected_accels.push_back(e);
        end
        loaded = 0;
        dropped = 1'b0;
    endfunction

    // Input driver: holds the payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_bodies.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_pos_x <= pending_bodies[0].px;
                i_pos_y <= pending_bodies[0].py;
                i_pos_z <= pending_bodies[0].pz;
                i_body_mass <= pending_bodies[0].mass;
                i_step_bin <= pending_bodies[0].bin;
                i_last_body <= pending_bodies[0].last;
                void'(pending_bodies.pop_front());
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: mirror config, predict on input transfer, check output transfer
    always @(posedge i_clk) begin
        body_t  b;
        accel_t e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("[softened_nbody_accel] ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (cfg_reg_t'(i_cfg_index))
                    REG_GRAV:   g_shadow <= i_cfg_data;
                    REG_SOFT:   eps_shadow <= i_cfg_data;
                    REG_ACTIVE: abin_shadow <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                b.px = i_pos_x;
                b.py = i_pos_y;
                b.pz = i_pos_z;
                b.mass = i_body_mass;
                b.bin = i_step_bin;
                b.last = i_last_body;
                absorb_body(b);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_accels.size() == 0) begin
                    report($sformatf("unexpected result for body %0d", o_body_index));
                end else begin
                    e = expected_accels.pop_front();
                    if (o_body_index !== e.idx)
                        report($sformatf("index %0d, want %0d", o_body_index, e.idx));
                    if (o_acc_x !== e.ax)
                        report($sformatf("body %0d acc_x %h, want %h", e.idx, o_acc_x, e.ax));
                    if (o_acc_y !== e.ay)
                        report($sformatf("body %0d acc_y %h, want %h", e.idx, o_acc_y, e.ay));
                    if (o_acc_z !== e.az)
                        report($sformatf("body %0d acc_z %h, want %h", e.idx, o_acc_z, e.az));
                    if (o_updated !== e.upd)
                        report($sformatf("body %0d updated %b", e.idx, o_updated));
                    if (o_zero_mass !== e.zm)
                        report($sformatf("body %0d zero_mass %b", e.idx, o_zero_mass));
                    if (o_saturated !== e.sat)
                        report($sformatf("body %0d saturated %b", e.idx, o_saturated));
                    if (o_overflowed !== e.ovf)
                        report($sformatf("body %0d overflowed %b", e.idx, o_overflowed));
                    if (o_last_result !== e.lastr)
                        report($sformatf("body %0d last_result %b", e.idx, o_last_result));
                end
            end
        end
    end

    task automatic add_body(input logic [31:0] x, y, z, m, input logic [1:0] bin,
                            input logic last);
        body_t b;
        b.px = x;
        b.py = y;
        b.pz = z;
        b.mass = m;
        b.bin = bin;
        b.last = last;
        pending_bodies.push_back(b);
    endtask

    function automatic logic [31:0] rand_coord(logic [31:0] prev);
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            2: return 32'($signed($urandom_range(0, 1 << 11)) - (1 << 10));
            3: return prev;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(5))
            0: return '0;
            1: return $urandom;
            2: return $urandom_range(1, 255);
            default: return $urandom_range(1 << 12, 1 << 20);
        endcase
    endfunction

    // One set of n bodies; coordinates sometimes repeat for zero-distance pairs
    task automatic add_set(input int n);
        logic [31:0] x = '0, y = '0, z = '0;
        for (int k = 0; k < n; k++) begin
            x = rand_coord(x);
            y = rand_coord(y);
            z = rand_coord(z);
            add_body(x, y, z, rand_mass(), 2'($urandom_range(3)), k == n - 1);
        end
    endtask

    // Sender holds off until every expected result is back and the block is quiet
    task automatic drain();
        while (pending_bodies.size() > 0 || i_in_valid || expected_accels.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int sets, input int ip, input int sp);
        idle_pct = ip;
        stall_pct = sp;
        for (int s = 0; s < sets; s++) add_set($urandom_range(1, 5));
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single body, coincident pair, extremes, zero mass, all bins
        cfg_write(REG_GRAV, 32'd662395188);
        cfg_write(REG_SOFT, 32'd0);
        cfg_write(REG_ACTIVE, 2'd0);
        add_body(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 2'd0, 1'b1);
        add_body(32'h0002_0000, 32'h5, 32'h7, 32'h0001_0000, 2'd1, 1'b0);
        add_body(32'h0002_0000, 32'h5, 32'h7, 32'h0003_0000, 2'd2, 1'b1);
        add_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b0);
        add_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 2'd0, 1'b0);
        add_body(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 2'd1, 1'b0);
        add_body(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 2'd2, 1'b1);
        drain();
        cfg_write(REG_ACTIVE, 2'd2);
        cfg_write(REG_SOFT, 32'hFFFF_FFFF);
        cfg_write(REG_GRAV, 32'hFFFF_FFFF);
        add_body(32'h0010_0000, 32'h0, 32'h0, 32'h0001_0000, 2'd0, 1'b0);
        add_body(32'h0000_0000, 32'h0, 32'h0, 32'h0002_0000, 2'd3, 1'b0);
        add_body(32'hFFF0_0000, 32'h0, 32'h0, 32'h0000_0000, 2'd2, 1'b0);
        add_body(32'h0000_1000, 32'h1, 32'h2, 32'h0000_8000, 2'd1, 1'b1);
        drain();

        // Random sets under several register settings and flow-control mixes
        cfg_write(REG_GRAV, 32'd662395188);
        cfg_write(REG_SOFT, 32'h0000_0100);
        cfg_write(REG_ACTIVE, 2'd0);
        random_phase(25, 0, 0);
        cfg_write(REG_GRAV, 32'd0);
        cfg_write(REG_ACTIVE, 2'd1);
        random_phase(10, 83, 0);
        cfg_write(REG_GRAV, $urandom);
        cfg_write(REG_SOFT, $urandom);
        cfg_write(REG_ACTIVE, 2'd3);
        random_phase(25, 0, 83);
        cfg_write(REG_GRAV, 32'hFFFF_FFFF);
        cfg_write(REG_SOFT, 32'd0);
        cfg_write(REG_ACTIVE, 2'd0);
        random_phase(25, 6, 6);
        cfg_write(REG_GRAV, 32'd662395188);
        cfg_write(REG_SOFT, 32'h0001_0000);
        cfg_write(REG_ACTIVE, 2'd2);
        random_phase(25, 83, 0);

        // Capacity exceeded: two sets beyond MAX_BODIES, one dropping its last body
        cfg_write(REG_ACTIVE, 2'd3);
        idle_pct = 6;
        stall_pct = 6;
        add_set(MAX_BODIES + 2);
        add_set(MAX_BODIES + 1);
        drain();

        repeat (200) @(posedge i_clk);
        if (expected_accels.size() > 0)
            report($sformatf("%0d results never arrived", expected_accels.size()));
        if (errors == 0) begin
            $display("[softened_nbody_accel] OK");
        end else begin
            $display("[softened_nbody_accel] ERROR");
        end
        $finish;
    end

endmodule
